// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the clocked concurrent assertions of the PID checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on aclk, disabled while aresetn is low
`define PIDFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, disabled while aresetn is low
`define PIDFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pidfd_pkg.sv
// ----------------------------------------------------------------------------
// pidfd_pkg
// Types, constants and helper functions of the filtered-derivative PID.
// ----------------------------------------------------------------------------
package pidfd_pkg;

    typedef logic [31:0]        word_t;
    typedef logic signed [63:0] prod_t;
    typedef logic [2:0]         cfg_idx_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_PROP_GAIN     = 3'd0;
    localparam cfg_idx_t CFG_INTEG_GAIN    = 3'd1;
    localparam cfg_idx_t CFG_DERIV_GAIN    = 3'd2;
    localparam cfg_idx_t CFG_BACKCALC_GAIN = 3'd3;
    localparam cfg_idx_t CFG_OUT_LOWER     = 3'd4;
    localparam cfg_idx_t CFG_OUT_UPPER     = 3'd5;
    localparam cfg_idx_t CFG_INTEG_LOWER   = 3'd6;
    localparam cfg_idx_t CFG_INTEG_UPPER   = 3'd7;

    // Register reset values
    localparam word_t RST_PROP_GAIN  = 32'd65536;
    localparam word_t RST_LIMIT_HIGH = 32'd1000000;
    localparam word_t RST_LIMIT_LOW  = 32'd0 - 32'd1000000;

    // Q15 low-pass coefficients
    localparam int    SMOOTH_ALPHA_Q15 = 12648;
    localparam int    SLOPE_ON_SENSED  = 1;
    localparam word_t ALPHA_NEW        = 32'(SMOOTH_ALPHA_Q15);
    localparam word_t ALPHA_OLD        = 32'(32768 - SMOOTH_ALPHA_Q15);

    // Accumulator saturation bounds
    localparam logic signed [32:0] SAT_POS = 33'sd2147483647;
    localparam logic signed [32:0] SAT_NEG = -33'sd2147483647;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_FA,
        ST_MUL_FB,
        ST_FILT,
        ST_MUL_D,
        ST_SUM,
        ST_CLAMP,
        ST_BC,
        ST_BC_ACC,
        ST_DONE
    } state_t;

    function automatic word_t clamp32(input word_t v, input word_t lo, input word_t hi);
        word_t r;
        if ($signed(v) > $signed(hi)) begin
            r = hi;
        end else if ($signed(v) < $signed(lo)) begin
            r = lo;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Saturating add into the accumulated error, then clamp
    function automatic word_t accum32(input word_t base, input word_t add,
                                      input word_t lo, input word_t hi);
        logic signed [32:0] s;
        word_t              sat;
        s = $signed({base[31], base}) + $signed({add[31], add});
        if (s > SAT_POS) begin
            sat = SAT_POS[31:0];
        end else if (s < SAT_NEG) begin
            sat = SAT_NEG[31:0];
        end else begin
            sat = s[31:0];
        end
        return clamp32(sat, lo, hi);
    endfunction

    function automatic word_t mag32(input word_t v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

// File: rtl/core/pidfd_mul.sv
// ----------------------------------------------------------------------------
// pidfd_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module pidfd_mul import pidfd_pkg::*; (
    input  logic  aclk,
    input  word_t mul_a,
    input  word_t mul_b,
    output prod_t prod_reg
);

    prod_t prod_next;

    assign prod_next = $signed(mul_a) * $signed(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// File: rtl/core/pid_controller_filtered_deriv.sv
// ----------------------------------------------------------------------------
// pid_controller_filtered_deriv
// Fixed-point PID with Q15-filtered derivative and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// Each input word carries a target and a sensed value; each result word
// carries the clamped drive plus peak |error|, peak |drive| and a sample
// count. All products run through one shared 32x32 multiplier, used six
// times per sample (P, I, two filter taps, D, back-calculation). A sample
// steps through DIFF, MUL_P, MUL_I, MUL_FA, MUL_FB, FILT, MUL_D, SUM, CLAMP,
// BC, BC_ACC when back-calculation fires, and DONE, where the result is loaded
// into the output register once it is free; the input is ready again only
// then, so samples are taken one at a time. A finished result waits in that
// register while the next sample is taken and worked on. Configuration
// writes are taken every cycle; write them only while no sample is in flight.
// ----------------------------------------------------------------------------
module pid_controller_filtered_deriv import pidfd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] target_value, [63:32] sensed_value
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] drive_value, [63:32] peak_abs_error,
                                    // [95:64] peak_abs_drive, [127:96] sample_count
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  cfg_idx_t     cfg_index,
    input  word_t        cfg_data
);

    // ---------------- configuration registers ----------------
    word_t prop_gain_reg, integ_gain_reg, deriv_gain_reg, backcalc_gain_reg;
    word_t out_lower_reg, out_upper_reg, integ_lower_reg, integ_upper_reg;

    // ---------------- controller state ----------------
    word_t error_sum_reg, last_sensed_reg, last_error_reg, smoothed_reg;
    word_t update_total_reg, worst_error_reg, worst_drive_reg;

    // ---------------- per-sample working registers ----------------
    word_t tgt_reg, sen_reg, err_reg, slope_reg, total_reg, filt_reg, drive_reg;

    state_t        state_reg, state_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [127:0]  m_tdata_reg;
    logic          load_out;
    logic          bc_needed;

    word_t mul_a, mul_b;
    prod_t prod_reg;
    word_t prod_q16;   // product >>> 16, low word
    word_t prod_q15;   // product >>> 15, low word

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign prod_q16  = prod_reg[47:16];
    assign prod_q15  = prod_reg[46:15];

    // Back-calculation fires only when the clamp changed the sum
    assign bc_needed = (backcalc_gain_reg != 32'd0) && (drive_reg != total_reg);

    // Output register frees up when empty or being drained this cycle
    assign load_out  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // ---------------- shared multiplier ----------------
    pidfd_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    // Operand select: each multiply step feeds its gain and signal
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_P: begin
                mul_a = prop_gain_reg;
                mul_b = err_reg;
            end
            ST_MUL_I: begin
                mul_a = integ_gain_reg;
                mul_b = error_sum_reg;
            end
            ST_MUL_FA: begin
                mul_a = ALPHA_NEW;
                mul_b = slope_reg;
            end
            ST_MUL_FB: begin
                mul_a = ALPHA_OLD;
                mul_b = smoothed_reg;
            end
            ST_MUL_D: begin
                mul_a = deriv_gain_reg;
                mul_b = smoothed_reg;
            end
            ST_BC: begin
                mul_a = backcalc_gain_reg;
                mul_b = drive_reg - total_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) begin
                state_next = ST_DIFF;
            end
            ST_DIFF:   state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_FA;
            ST_MUL_FA: state_next = ST_MUL_FB;
            ST_MUL_FB: state_next = ST_FILT;
            ST_FILT:   state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_BC;
            ST_BC:     state_next = bc_needed ? ST_BC_ACC : ST_DONE;
            ST_BC_ACC: state_next = ST_DONE;
            ST_DONE:   if (load_out) begin
                state_next    = ST_IDLE;
                m_tvalid_next = 1'b1;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- configuration writes ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= RST_PROP_GAIN;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            backcalc_gain_reg <= '0;
            out_lower_reg     <= RST_LIMIT_LOW;
            out_upper_reg     <= RST_LIMIT_HIGH;
            integ_lower_reg   <= RST_LIMIT_LOW;
            integ_upper_reg   <= RST_LIMIT_HIGH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                CFG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                CFG_BACKCALC_GAIN: backcalc_gain_reg <= cfg_data;
                CFG_OUT_LOWER:     out_lower_reg     <= cfg_data;
                CFG_OUT_UPPER:     out_upper_reg     <= cfg_data;
                CFG_INTEG_LOWER:   integ_lower_reg   <= cfg_data;
                CFG_INTEG_UPPER:   integ_upper_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- controller state updates ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg    <= '0;
            last_sensed_reg  <= '0;
            last_error_reg   <= '0;
            smoothed_reg     <= '0;
            update_total_reg <= '0;
            worst_error_reg  <= '0;
            worst_drive_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_DIFF: begin
                    // Slope source is fixed at build time
                    if (SLOPE_ON_SENSED != 0) begin
                        last_sensed_reg <= sen_reg;
                    end
                    last_error_reg <= tgt_reg - sen_reg;
                end
                ST_MUL_P: begin
                    error_sum_reg <= accum32(error_sum_reg, err_reg,
                                             integ_lower_reg, integ_upper_reg);
                    if (mag32(err_reg) > worst_error_reg) begin
                        worst_error_reg <= mag32(err_reg);
                    end
                end
                ST_FILT: begin
                    // Wrap the two filter taps into the new smoothed slope
                    smoothed_reg <= filt_reg + prod_q15;
                end
                ST_BC: begin
                    update_total_reg <= update_total_reg + 32'd1;
                    if (mag32(drive_reg) > worst_drive_reg) begin
                        worst_drive_reg <= mag32(drive_reg);
                    end
                end
                ST_BC_ACC: begin
                    error_sum_reg <= accum32(error_sum_reg, prod_q16,
                                             integ_lower_reg, integ_upper_reg);
                end
                default: ;
            endcase
        end
    end

    // ---------------- per-sample datapath ----------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                // Capture the input word on acceptance
                if (s_tvalid) begin
                    tgt_reg <= s_tdata[31:0];
                    sen_reg <= s_tdata[63:32];
                end
            end
            ST_DIFF: begin
                err_reg <= tgt_reg - sen_reg;
                if (SLOPE_ON_SENSED != 0) begin
                    slope_reg <= sen_reg - last_sensed_reg;
                end else begin
                    slope_reg <= (tgt_reg - sen_reg) - last_error_reg;
                end
            end
            ST_MUL_I:  total_reg <= prod_q16;               // P term
            ST_MUL_FA: total_reg <= total_reg + prod_q16;   // add I term
            ST_MUL_FB: filt_reg  <= prod_q15;               // new-slope tap
            ST_SUM:    total_reg <= total_reg + prod_q16;   // add D term
            ST_CLAMP:  drive_reg <= clamp32(total_reg, out_lower_reg, out_upper_reg);
            ST_DONE: begin
                if (load_out) begin
                    m_tdata_reg <= {update_total_reg, worst_drive_reg,
                                    worst_error_reg, drive_reg};
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/pidfd_checker.sv
// ----------------------------------------------------------------------------
// pidfd_checker
// Port-level checks of the filtered-derivative PID, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidfd_checker import pidfd_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,    // drive, peak err, peak drive, count
    input logic         cfg_valid,
    input logic         cfg_ready
);

    word_t drive_mag;
    logic  out_stall;

    assign drive_mag = mag32(m_tdata[31:0]);
    assign out_stall = m_tvalid && !m_tready;

    // Block works on one sample at a time
    `PIDFD_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready, "ready after accept")

    // Peak drive never trails the drive it reports
    `PIDFD_ASSERT_NOW(a_peak, m_tvalid, m_tdata[95:64] >= drive_mag, "peak below drive")

    // Stalled result holds
    `PIDFD_ASSERT_NXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "result dropped")

    // Configuration channel never back-pressures
    `PIDFD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind pid_controller_filtered_deriv pidfd_checker u_pidfd_checker (.*);
